// File: sv/sie_pkg.sv
// shared types and constants for the signed integer extractor
// no dependencies; imported by every module of the block
package sie_pkg;

    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_NINE  = 8'h39;
    localparam logic [7:0]  CH_MINUS = 8'h2D;
    localparam int unsigned MAG_W    = 31;
    localparam logic [MAG_W-1:0] MAG_MAX = 31'h7FFF_FFFF;
    localparam int unsigned NUM_W    = 32;

    // one result item
    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic             saturated;
        logic             last_of_run;
    } t_result;

    // what one input byte produces: zero, one or two results, first in res0
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_parse_out;

endpackage

// File: sv/sie_parse.sv
// per-byte number parser: holds the number in progress and decodes one byte
// depends on sie_pkg
module sie_parse
    import sie_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_take,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output t_parse_out o_parse
);

    logic             r_in_number;
    logic             r_negative;
    logic [MAG_W-1:0] r_magnitude;
    logic             r_overflowed;

    logic             n_in_number;
    logic             n_negative;
    logic [MAG_W-1:0] n_magnitude;
    logic             n_overflowed;

    logic             digit_hit;
    logic             is_minus;
    logic [3:0]       digit;
    logic [MAG_W+3:0] times_ten;
    logic             over;
    logic [MAG_W-1:0] mag_acc;

    t_result          old_res;
    t_result          new_res;
    t_result          zero_res;

    function automatic t_result emit(input logic neg, input logic [MAG_W-1:0] mag,
                                     input logic ovf);
        t_result res;
        res.number      = neg ? (NUM_W'(0) - {1'b0, mag}) : {1'b0, mag};
        res.saturated   = ovf;
        res.last_of_run = 1'b0;
        return res;
    endfunction

    assign digit_hit = (i_text_byte >= CH_ZERO) && (i_text_byte <= CH_NINE);
    assign is_minus  = (i_text_byte == CH_MINUS);
    assign digit     = 4'(i_text_byte - CH_ZERO);

    // magnitude * 10 + digit as shift-add, saturating at the 31-bit limit
    assign times_ten = ({4'b0, r_magnitude} << 3) + ({4'b0, r_magnitude} << 1)
                     + (MAG_W+4)'(digit);
    assign over      = |times_ten[MAG_W+3:MAG_W];
    assign mag_acc   = over ? MAG_MAX : times_ten[MAG_W-1:0];

    always_comb begin
        n_in_number  = r_in_number;
        n_negative   = r_negative;
        n_magnitude  = r_magnitude;
        n_overflowed = r_overflowed;
        if (digit_hit) begin
            n_in_number = 1'b1;
            if (r_in_number) begin
                n_magnitude  = mag_acc;
                n_overflowed = r_overflowed | over;
            end else begin
                n_negative   = 1'b0;
                n_magnitude  = MAG_W'(digit);
                n_overflowed = 1'b0;
            end
        end else if (is_minus) begin
            n_in_number  = 1'b1;
            n_negative   = 1'b1;
            n_magnitude  = '0;
            n_overflowed = 1'b0;
        end else begin
            n_in_number  = 1'b0;
            n_negative   = 1'b0;
            n_magnitude  = '0;
            n_overflowed = 1'b0;
        end
    end

    assign old_res  = emit(r_negative, r_magnitude, r_overflowed);
    assign new_res  = emit(n_negative, n_magnitude, n_overflowed);
    assign zero_res = emit(1'b0, '0, 1'b0);

    always_comb begin
        o_parse       = '0;
        o_parse.res0  = old_res;
        o_parse.res1  = zero_res;
        if (digit_hit) begin
            o_parse.res0  = new_res;
            o_parse.count = i_end_of_text ? 2'd1 : 2'd0;
        end else if (is_minus) begin
            if (r_in_number) begin
                o_parse.count = i_end_of_text ? 2'd2 : 2'd1;
            end else begin
                o_parse.res0  = zero_res;
                o_parse.count = i_end_of_text ? 2'd1 : 2'd0;
            end
        end else begin
            o_parse.count = r_in_number ? 2'd1 : 2'd0;
        end
        // mark the final result of this byte
        if (o_parse.count == 2'd1) begin
            o_parse.res0.last_of_run = 1'b1;
        end else if (o_parse.count == 2'd2) begin
            o_parse.res1.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_number  <= 1'b0;
            r_negative   <= 1'b0;
            r_magnitude  <= '0;
            r_overflowed <= 1'b0;
        end else if (i_take) begin
            if (i_end_of_text) begin
                r_in_number  <= 1'b0;
                r_negative   <= 1'b0;
                r_magnitude  <= '0;
                r_overflowed <= 1'b0;
            end else begin
                r_in_number  <= n_in_number;
                r_negative   <= n_negative;
                r_magnitude  <= n_magnitude;
                r_overflowed <= n_overflowed;
            end
        end
    end

    // state only moves on a byte that is present
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> i_valid)
        else $error("parser consumed a byte that is not present");

    // a clamped number always carries the limit value
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_parse.count != 2'd0 && o_parse.res0.saturated) |->
        (o_parse.res0.number == 32'h7FFF_FFFF || o_parse.res0.number == 32'h8000_0001))
        else $error("saturated result without limit magnitude");

    // overflow flag never set without a number in progress
    a_ovf_in_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflowed |-> r_in_number)
        else $error("overflow flag set with no number in progress");

endmodule

// File: sv/sie_fifo.sv
// result queue: takes up to two results per cycle, hands out one per transfer
// depends on sie_pkg
module sie_fifo
    import sie_pkg::*;
#(
    parameter int unsigned DEPTH = 4    // power of two, at least 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [1:0]                   i_push_cnt,
    input  t_result                      i_push0,
    input  t_result                      i_push1,
    input  logic                         i_ready,
    output logic                         o_valid,
    output t_result                      o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_room
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH+1);

    t_result       r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign o_room  = CW'(DEPTH) - r_cnt + CW'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_push0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr + AW'(1)] <= i_push1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + AW'(i_push_cnt);
            r_rd  <= r_rd + AW'(pop);
            r_cnt <= r_cnt + CW'(i_push_cnt) - CW'(pop);
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(i_push_cnt) <= o_room)
        else $error("result queue overrun");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("result queue count out of range");

endmodule

// File: sv/signed_integer_extractor_unit.sv
// Signed integer extractor, top level. Takes one text byte per transfer on the
// slave stream (tlast marks the last byte of a string) and sends the decimal
// integers found in it on the master stream. Only '0'..'9' and '-' count; any
// other byte separates numbers. A '-' always opens a new number (a lone '-'
// gives 0), digits extend the number in progress, and a number goes out when a
// non-digit ends it or the string ends. Magnitudes clamp at 2147483647 and then
// tuser is set. A byte gives zero, one or two results; tlast on the master side
// marks the final result caused by that byte. Bytes are taken one per cycle
// while the queue has room: a byte sits in an input register, one pass of
// decode and shift-add logic updates the parser state, and its results go
// into a small result queue. The master side drains one result per cycle
// while tready is high, so a byte that gives two results (a '-' on the last
// byte after a number) costs an extra transfer; the queue depth P_FIFO_DEPTH
// sets how many such bytes are absorbed without stalling the slave side.
// depends on sie_pkg, sie_parse, sie_fifo
module signed_integer_extractor_unit
    import sie_pkg::*;
#(
    parameter int unsigned P_FIFO_DEPTH = 4   // power of two, at least 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream: text bytes
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] text_byte
    input  logic        i_s_axis_tlast,   // end_of_text
    // master stream: extracted numbers
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] number
    output logic        o_m_axis_tuser,   // [0] saturated
    output logic        o_m_axis_tlast    // last_of_run
);

    localparam int unsigned CW = $clog2(P_FIFO_DEPTH+1);

    // input register
    logic          r_in_vld;
    logic [7:0]    r_in_byte;
    logic          r_in_eot;

    t_parse_out    parse;
    logic [CW-1:0] room;
    logic          take;
    logic [1:0]    push_cnt;
    t_result       head;

    // byte leaves the input register once the queue can hold all its results
    assign take            = r_in_vld && (CW'(parse.count) <= room);
    assign o_s_axis_tready = !r_in_vld || take;
    assign push_cnt        = take ? parse.count : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (take) begin
            r_in_vld <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_eot  <= i_s_axis_tlast;
        end
    end

    sie_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_in_vld),
        .i_take        (take),
        .i_text_byte   (r_in_byte),
        .i_end_of_text (r_in_eot),
        .o_parse       (parse)
    );

    sie_fifo #(
        .DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_push0    (parse.res0),
        .i_push1    (parse.res1),
        .i_ready    (i_m_axis_tready),
        .o_valid    (o_m_axis_tvalid),
        .o_data     (head),
        .o_room     (room)
    );

    assign o_m_axis_tdata = head.number;
    assign o_m_axis_tuser = head.saturated;
    assign o_m_axis_tlast = head.last_of_run;

endmodule

// File: tb/tb.sv
// self-checking testbench for signed_integer_extractor_unit: text bytes with random gaps in,
// extracted numbers with random stalls out, checked against an in-bench parser model
// depends on sie_pkg and the signed_integer_extractor_unit rtl
`timescale 1ns / 100ps

import sie_pkg::*;

// parser model plus the queue of numbers still owed by the block
class number_scoreboard;
    bit               in_num;
    bit               neg;
    bit               ovf;
    logic [MAG_W-1:0] mag;
    t_result          owed[$];
    int               n_bytes;
    int               n_numbers;
    int               n_saturated;
    int               n_pairs;
    int               n_errors;

    function t_result take_number();
        t_result r;
        r.number      = neg ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
        r.saturated   = ovf;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    function void clear_number();
        in_num = 1'b0;
        neg    = 1'b0;
        mag    = '0;
        ovf    = 1'b0;
    endfunction

    // one accepted text byte: advance the parser and queue what it must emit
    function void note_byte(logic [7:0] b, logic eot);
        logic [63:0] acc;
        t_result     r0;
        t_result     r1;
        int          n;
        n = 0;
        n_bytes++;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            if (!in_num) begin
                in_num = 1'b1;
                neg    = 1'b0;
                mag    = MAG_W'(b - CH_ZERO);
                ovf    = 1'b0;
            end else begin
                acc = {33'd0, mag} * 64'd10 + {56'd0, b - CH_ZERO};
                if (acc > {33'd0, MAG_MAX}) begin
                    mag = MAG_MAX;
                    ovf = 1'b1;
                end else begin
                    mag = acc[MAG_W-1:0];
                end
            end
            if (eot) begin
                r0 = take_number();
                n  = 1;
            end
        end else if (b == CH_MINUS) begin
            // a minus closes any number in progress and opens a negative one
            if (in_num) begin
                r0 = take_number();
                n  = 1;
            end
            in_num = 1'b1;
            neg    = 1'b1;
            mag    = '0;
            ovf    = 1'b0;
            if (eot) begin
                if (n == 0) r0 = take_number();
                else        r1 = take_number();
                n++;
            end
        end else begin
            if (in_num) begin
                r0 = take_number();
                n  = 1;
            end
            clear_number();
        end
        if (eot) clear_number();
        if (n == 1) r0.last_of_run = 1'b1;
        if (n == 2) r1.last_of_run = 1'b1;
        if (n >= 1) owed.push_back(r0);
        if (n == 2) begin
            owed.push_back(r1);
            n_pairs++;
        end
    endfunction

    // one accepted number from the block
    function void check_result(logic [31:0] num, logic sat, logic lst);
        t_result e;
        if (owed.size() == 0) begin
            $error("unexpected number %0d (saturated %0b, last %0b)", $signed(num), sat, lst);
            n_errors++;
            return;
        end
        e = owed.pop_front();
        n_numbers++;
        if (e.saturated) n_saturated++;
        if (num !== e.number) begin
            $error("number: expected %0d, got %0d", $signed(e.number), $signed(num));
            n_errors++;
        end
        if (sat !== e.saturated) begin
            $error("saturated: expected %0b, got %0b", e.saturated, sat);
            n_errors++;
        end
        if (lst !== e.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", e.last_of_run, lst);
            n_errors++;
        end
    endfunction
endclass

module tb;

    localparam int          LIMIT_CYCLES  = 200000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          RANDOM_BYTES  = 400;
    localparam logic [7:0]  SEP_HIGH      = 8'hFF;
    localparam logic [7:0]  SEP_NUL       = 8'h00;
    localparam logic [7:0]  SEP_SPACE     = 8'h20;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;

    number_scoreboard sb = new();
    bit               tx_burst;     // sender runs with no gaps
    bit               rx_burst;     // receiver runs with no stalls
    int               rx_wait;
    int               cycles;

    signed_integer_extractor_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),          // [7:0] text_byte
        .i_s_axis_tlast  (s_tlast),          // end_of_text
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [31:0] number
        .o_m_axis_tuser  (o_m_axis_tuser),   // [0] saturated
        .o_m_axis_tlast  (o_m_axis_tlast)    // last_of_run
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // watchdog against a hung handshake
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d numbers still owed", cycles, sb.owed.size());
            $display("signed_integer_extractor_unit regression: fail");
            $finish;
        end
    end

    // result side: check each transfer, then stall for a random number of cycles
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tready && o_m_axis_tvalid) begin
                sb.check_result(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 16);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_tready <= (rx_wait == 0);
        end
    end

    // one text byte transfer, after a random gap with tvalid low
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_byte(b, eot);
    endtask

    // whole string, end flag optionally on its final byte
    task automatic send_text(input string s, input bit eot);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], eot && (i == s.len() - 1));
    endtask

    // hold off the sender until every owed number has come back
    task automatic wait_all_numbers();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.owed.size() != 0);
    endtask

    // a number-shaped token with random content and a random way of ending it
    task automatic send_random_token();
        int         len;
        logic [7:0] b;
        tx_burst = ($urandom_range(0, 5) == 0);
        case ($urandom_range(0, 9))
            0: begin
                // plain noise, any byte value
                len = $urandom_range(1, 4);
                repeat (len) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
            1: begin
                // magnitudes around the clamp point
                case ($urandom_range(0, 3))
                    0: send_text("2147483647", 1'b0);
                    1: send_text("2147483648", 1'b0);
                    2: send_text("-2147483647", 1'b0);
                    default: send_text("-99999999999", 1'b0);
                endcase
            end
            default: begin
                if ($urandom_range(0, 2) == 0) send_byte(CH_MINUS, 1'b0);
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
                repeat (len) send_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            end
        endcase
        case ($urandom_range(0, 5))
            0, 1: begin
                // separator, kept out of the digit and minus codes
                do b = 8'($urandom_range(0, 255));
                while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS);
                send_byte(b, $urandom_range(0, 3) == 0);
            end
            2: send_byte(CH_MINUS, $urandom_range(0, 1) == 1);
            3: ;    // next token runs straight on
            4: send_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b1);
            default: send_byte(SEP_SPACE, 1'b1);
        endcase
    endtask

    initial begin
        int start_bytes;
        bit paused;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: lone minus at end of text, minus on the last byte after a number,
        // double minus, negative zero, byte extremes, range edges of the digit codes,
        // saturation of a long digit run
        send_text("-", 1'b1);
        send_text("5-", 1'b1);
        send_text("--5", 1'b1);
        send_text("-0", 1'b0);
        send_byte(SEP_HIGH, 1'b0);
        send_byte(SEP_NUL, 1'b1);
        send_text("7:", 1'b0);
        send_text("/", 1'b1);
        send_text("99999999999", 1'b1);
        wait_all_numbers();

        // random: mostly well-formed numbers, some noise and broken tokens
        start_bytes = sb.n_bytes;
        paused      = 1'b0;
        while (sb.n_bytes - start_bytes < RANDOM_BYTES) begin
            send_random_token();
            if (!paused && sb.n_bytes - start_bytes >= RANDOM_BYTES / 2) begin
                wait_all_numbers();
                paused = 1'b1;
            end
        end
        // close any open string so the last number comes out
        send_byte(SEP_SPACE, 1'b1);

        wait_all_numbers();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d text bytes and %0d numbers, %0d of them saturated,",
                 sb.n_bytes, sb.n_numbers, sb.n_saturated);
        $display("with %0d bytes that each closed one number and opened another at end of text",
                 sb.n_pairs);
        if (sb.n_errors == 0 && sb.owed.size() == 0) begin
            $display("signed_integer_extractor_unit regression: pass");
        end else begin
            $display("signed_integer_extractor_unit regression: fail");
        end
        $finish;
    end

endmodule
